@@ hw/rtl/clock_setting_and_digit_display_assert.svh @@
// assertion macros shared by the clock setting and digit display rtl
// no dependencies; the macros expand to nothing when SYNTH is defined
`ifndef CLOCK_SETTING_AND_DIGIT_DISPLAY_ASSERT_SVH
`define CLOCK_SETTING_AND_DIGIT_DISPLAY_ASSERT_SVH
`ifndef SYNTH
`define CLSD_ASSERT(name, c, r, prop) \
	name: assert property (@(posedge c) disable iff (!r) prop) \
		else $error("clsd assertion failed");
`define CLSD_ASSERT_IMPL(name, c, r, ante, cons) \
	name: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
		else $error("clsd implication failed");
`define CLSD_ASSERT_NEXT(name, c, r, ante, cons) \
	name: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
		else $error("clsd next-cycle check failed");
`else
`define CLSD_ASSERT(name, c, r, prop)
`define CLSD_ASSERT_IMPL(name, c, r, ante, cons)
`define CLSD_ASSERT_NEXT(name, c, r, ante, cons)
`endif
`endif

@@ hw/rtl/clsd_pkg.sv @@
// types, constants and functions of the clock setting and digit display block
// no dependencies
package clsd_pkg;

	localparam int VAL_W = 7;
	localparam int CODE_W = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [VAL_W-1:0] YEAR_WRAP_HIGH_RST = 7'd50;
	localparam logic [VAL_W-1:0] YEAR_WRAP_LOW_RST = 7'd18;

	localparam logic [VAL_W:0] HOUR_MAX = 8'd23;
	localparam logic [VAL_W:0] MINUTE_MAX = 8'd59;
	localparam logic [VAL_W:0] MONTH_MAX = 8'd12;
	localparam logic [VAL_W:0] DAYS_LONG = 8'd31;
	localparam logic [VAL_W:0] DAYS_SHORT = 8'd30;
	localparam logic [VAL_W:0] DAYS_FEB_LEAP = 8'd29;
	localparam logic [VAL_W:0] DAYS_FEB = 8'd28;
	localparam logic [VAL_W-1:0] MONTH_FEB = 7'd2;
	// the only year below 128 that is a multiple of four but not a leap year
	localparam logic [VAL_W-1:0] CENTURY_NON_LEAP = 7'd100;

	// adjust field codes
	localparam logic [1:0] ADJ_OFF = 2'd0;
	localparam logic [1:0] ADJ_FIRST = 2'd1;
	localparam logic [1:0] ADJ_SECOND = 2'd2;
	localparam logic [1:0] ADJ_THIRD = 2'd3;

	// register indexes
	localparam logic REG_YEAR_WRAP_HIGH = 1'b0;
	localparam logic REG_YEAR_WRAP_LOW = 1'b1;

	// digit positions
	localparam logic [2:0] POS_LAST = 3'd7;
	localparam logic [CODE_W-1:0] BLANK_CODE = 5'h10;
	// reciprocal of ten scaled by 2^11, exact for values below 128
	localparam logic [7:0] DIV10_MUL = 8'd205;

	typedef struct packed {
		logic date_view;
		logic rtc_write;
		logic [VAL_W-1:0] hour;
		logic [VAL_W-1:0] minute;
		logic [VAL_W-1:0] second;
		logic [VAL_W-1:0] year;
		logic [VAL_W-1:0] month;
		logic [VAL_W-1:0] day;
	} scan_rec_t;

	function automatic logic [7:0] seg_of(input logic [CODE_W-1:0] code);
		logic [7:0] s;
		case (code)
			5'd0: s = 8'h3F;
			5'd1: s = 8'h06;
			5'd2: s = 8'h5B;
			5'd3: s = 8'h4F;
			5'd4: s = 8'h66;
			5'd5: s = 8'h6D;
			5'd6: s = 8'h7D;
			5'd7: s = 8'h07;
			5'd8: s = 8'h7F;
			5'd9: s = 8'h6F;
			5'd10: s = 8'h77;
			5'd11: s = 8'h7C;
			5'd12: s = 8'h39;
			5'd13: s = 8'h5E;
			5'd14: s = 8'h79;
			5'd15: s = 8'h71;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

@@ hw/rtl/clsd_if.sv @@
// scan and digit channel interfaces of the clock setting and digit display block
// depends on clsd_pkg for the value width
interface clsd_scan_if;
	logic valid;
	logic ready;
	logic set_key_level;
	logic op_key_level;
	logic [clsd_pkg::VAL_W-1:0] cur_hour;
	logic [clsd_pkg::VAL_W-1:0] cur_minute;
	logic [clsd_pkg::VAL_W-1:0] cur_second;
	logic [clsd_pkg::VAL_W-1:0] cur_year;
	logic [clsd_pkg::VAL_W-1:0] cur_month;
	logic [clsd_pkg::VAL_W-1:0] cur_day;
	modport source (
		output valid, set_key_level, op_key_level,
		output cur_hour, cur_minute, cur_second, cur_year, cur_month, cur_day,
		input ready
	);
	modport sink (
		input valid, set_key_level, op_key_level,
		input cur_hour, cur_minute, cur_second, cur_year, cur_month, cur_day,
		output ready
	);
endinterface

interface clsd_digit_if;
	logic valid;
	logic ready;
	logic [7:0] digit_select;
	logic [7:0] segment_bits;
	logic last_digit;
	logic rtc_write;
	logic [clsd_pkg::VAL_W-1:0] new_hour;
	logic [clsd_pkg::VAL_W-1:0] new_minute;
	logic [clsd_pkg::VAL_W-1:0] new_second;
	logic [clsd_pkg::VAL_W-1:0] new_year;
	logic [clsd_pkg::VAL_W-1:0] new_month;
	logic [clsd_pkg::VAL_W-1:0] new_day;
	modport source (
		output valid, digit_select, segment_bits, last_digit, rtc_write,
		output new_hour, new_minute, new_second, new_year, new_month, new_day,
		input ready
	);
	modport sink (
		input valid, digit_select, segment_bits, last_digit, rtc_write,
		input new_hour, new_minute, new_second, new_year, new_month, new_day,
		output ready
	);
endinterface

@@ hw/rtl/clock_setting_and_digit_display.sv @@
// path: a scan transfer reaches the digit output through the queue, the record register and the output register
// throughput: eight digit transfers per scan, with no gap between queued scans when the sink
// takes a digit each cycle; the single digit output register sets that pace
// reset: arst_n clears key, view, mode and pending state and loads the year wrap
// registers with 50 and 18; no memory clearing pass, the block is ready at once
// top level: apb registers, scan front end, record queue and digit back end
module clock_setting_and_digit_display #(
	parameter int QUEUE_DEPTH = clsd_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	clsd_scan_if.sink    scan,
	clsd_digit_if.source digit,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import clsd_pkg::*;

	// configuration registers
	logic [VAL_W-1:0] year_wrap_high_q;
	logic [VAL_W-1:0] year_wrap_low_q;
	logic reg_idx;
	logic wr_en;

	// front to queue and queue to back
	logic q_full, q_push, q_pop, q_valid;
	scan_rec_t q_push_rec, q_head;

	// register i sits at byte address 4*i, so bit two picks the register
	assign reg_idx = paddr[2];
	assign pready = 1'b1;
	// write lands in the access phase of the transfer
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_wrap_high_q <= YEAR_WRAP_HIGH_RST;
			year_wrap_low_q <= YEAR_WRAP_LOW_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_YEAR_WRAP_HIGH: year_wrap_high_q <= pwdata[VAL_W-1:0];
				REG_YEAR_WRAP_LOW: year_wrap_low_q <= pwdata[VAL_W-1:0];
				default: year_wrap_high_q <= year_wrap_high_q;
			endcase
		end
	end

	// read back, zero above the seven value bits
	always_comb begin
		case (reg_idx)
			REG_YEAR_WRAP_HIGH: prdata = {25'd0, year_wrap_high_q};
			REG_YEAR_WRAP_LOW: prdata = {25'd0, year_wrap_low_q};
			default: prdata = '0;
		endcase
	end

	// front end classifies keys and applies any increment in the cycle of the transfer
	clsd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.scan           (scan),
		.year_wrap_high (year_wrap_high_q),
		.year_wrap_low  (year_wrap_low_q),
		.q_full         (q_full),
		.push           (q_push),
		.push_rec       (q_push_rec)
	);

	// queue lets the front take the next scan while digits are still going out
	clsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (q_push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// back end emits eight digit transfers per record through its output register
	clsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (q_pop),
		.digit   (digit)
	);
endmodule

@@ hw/rtl/clsd_queue.sv @@
// short record queue between the scan front end and the digit back end
// depends on clsd_pkg and the assertion macro header
`include "clock_setting_and_digit_display_assert.svh"
module clsd_queue #(
	parameter int DEPTH = clsd_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  clsd_pkg::scan_rec_t  push_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output clsd_pkg::scan_rec_t  head
);
	import clsd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	scan_rec_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CLSD_ASSERT(a_queue_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`CLSD_ASSERT_IMPL(a_queue_no_overflow, clk, arst_n, push, !full)
	`CLSD_ASSERT_IMPL(a_queue_no_underflow, clk, arst_n, pop, not_empty)
endmodule

@@ hw/rtl/clsd_front.sv @@
// scan front end: key release detection, mode state and field increment
// depends on clsd_pkg, clsd_if and the assertion macro header
`include "clock_setting_and_digit_display_assert.svh"
module clsd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	clsd_scan_if.sink                    scan,
	input  logic [clsd_pkg::VAL_W-1:0]   year_wrap_high,
	input  logic [clsd_pkg::VAL_W-1:0]   year_wrap_low,
	input  logic                         q_full,
	output logic                         push,
	output clsd_pkg::scan_rec_t          push_rec
);
	import clsd_pkg::*;

	logic op_held_q, set_held_q, date_view_q, pend_q;
	logic [1:0] adj_q;

	logic op_held_d, set_held_d, date_view_d, pend_d, apply;
	logic [1:0] adj_d;
	logic [VAL_W:0] inc_sum, day_lim;
	logic [VAL_W-1:0] inc_src, inc_res;
	logic leap;

	assign scan.ready = !q_full;
	assign push = scan.valid && !q_full;

	// key handling, operation key before setting key
	always_comb begin
		op_held_d = op_held_q;
		set_held_d = set_held_q;
		date_view_d = date_view_q;
		pend_d = pend_q;
		adj_d = adj_q;
		if (!scan.op_key_level && !op_held_q) begin
			op_held_d = 1'b1;
		end else if (scan.op_key_level && op_held_q) begin
			op_held_d = 1'b0;
			if (adj_q != ADJ_OFF) begin
				pend_d = 1'b1;
			end else begin
				date_view_d = !date_view_q;
			end
		end
		if (!scan.set_key_level && !set_held_q) begin
			set_held_d = 1'b1;
		end else if (scan.set_key_level && set_held_q) begin
			set_held_d = 1'b0;
			adj_d = adj_q + 2'd1;
		end
		apply = (adj_d != ADJ_OFF) && pend_d;
	end

	// day limit of the scanned month and year
	always_comb begin
		leap = (scan.cur_year[1:0] == 2'b00) && (scan.cur_year != CENTURY_NON_LEAP);
		if (scan.cur_month inside {7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12}) begin
			day_lim = DAYS_LONG;
		end else if (scan.cur_month == MONTH_FEB) begin
			day_lim = leap ? DAYS_FEB_LEAP : DAYS_FEB;
		end else begin
			day_lim = DAYS_SHORT;
		end
	end

	// one shared incrementer, the field picks the source and the wrap rule
	always_comb begin
		case (adj_d)
			ADJ_FIRST: inc_src = date_view_d ? scan.cur_year : scan.cur_hour;
			ADJ_SECOND: inc_src = date_view_d ? scan.cur_month : scan.cur_minute;
			default: inc_src = date_view_d ? scan.cur_day : scan.cur_second;
		endcase
		inc_sum = {1'b0, inc_src} + 1'b1;
		case (adj_d)
			ADJ_FIRST: begin
				if (date_view_d) begin
					inc_res = (inc_sum > {1'b0, year_wrap_high}) ? year_wrap_low
						: inc_sum[VAL_W-1:0];
				end else begin
					inc_res = (inc_sum > HOUR_MAX) ? '0 : inc_sum[VAL_W-1:0];
				end
			end
			ADJ_SECOND: begin
				if (date_view_d) begin
					inc_res = (inc_sum > MONTH_MAX) ? '0 : inc_sum[VAL_W-1:0];
				end else begin
					inc_res = (inc_sum > MINUTE_MAX) ? '0 : inc_sum[VAL_W-1:0];
				end
			end
			default: begin
				if (date_view_d) begin
					inc_res = (inc_sum > day_lim) ? '0 : inc_sum[VAL_W-1:0];
				end else begin
					inc_res = (inc_sum > MINUTE_MAX) ? '0 : inc_sum[VAL_W-1:0];
				end
			end
		endcase
	end

	always_comb begin
		push_rec.date_view = date_view_d;
		push_rec.rtc_write = apply;
		push_rec.hour = scan.cur_hour;
		push_rec.minute = scan.cur_minute;
		push_rec.second = scan.cur_second;
		push_rec.year = scan.cur_year;
		push_rec.month = scan.cur_month;
		push_rec.day = scan.cur_day;
		if (apply) begin
			case (adj_d)
				ADJ_FIRST: begin
					if (date_view_d) begin
						push_rec.year = inc_res;
					end else begin
						push_rec.hour = inc_res;
					end
				end
				ADJ_SECOND: begin
					if (date_view_d) begin
						push_rec.month = inc_res;
					end else begin
						push_rec.minute = inc_res;
					end
				end
				ADJ_THIRD: begin
					if (date_view_d) begin
						push_rec.day = inc_res;
					end else begin
						push_rec.second = inc_res;
					end
				end
				default: begin
					push_rec.hour = scan.cur_hour;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_held_q <= 1'b0;
			set_held_q <= 1'b0;
			date_view_q <= 1'b0;
			adj_q <= ADJ_OFF;
			pend_q <= 1'b0;
		end else if (push) begin
			op_held_q <= op_held_d;
			set_held_q <= set_held_d;
			date_view_q <= date_view_d;
			adj_q <= adj_d;
			pend_q <= pend_d && !apply;
		end
	end

	`CLSD_ASSERT_IMPL(a_front_write_needs_mode, clk, arst_n, push && push_rec.rtc_write, adj_d != ADJ_OFF)
	`CLSD_ASSERT_NEXT(a_front_pending_cleared, clk, arst_n, push && push_rec.rtc_write, !pend_q)
endmodule

@@ hw/rtl/clsd_back.sv @@
// digit back end: walks one scan record over eight digit positions
// depends on clsd_pkg, clsd_if and the assertion macro header
`include "clock_setting_and_digit_display_assert.svh"
module clsd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  clsd_pkg::scan_rec_t  q_head,
	output logic                 pop,
	clsd_digit_if.source         digit
);
	import clsd_pkg::*;

	logic busy_q;
	logic [2:0] pos_q;
	scan_rec_t rec_q;

	logic out_valid_q;
	logic [7:0] sel_q, seg_q;
	logic last_q;
	scan_rec_t out_rec_q;

	logic advance, at_last;
	logic [VAL_W-1:0] val;
	logic [14:0] prod;
	logic [3:0] tens, units;
	logic [CODE_W-1:0] code;

	assign advance = busy_q && (!out_valid_q || digit.ready);
	assign at_last = (pos_q == POS_LAST);
	assign pop = q_valid && (!busy_q || (advance && at_last));

	// field for the digit pair, tens by reciprocal multiply
	always_comb begin
		case (pos_q)
			3'd0, 3'd1, 3'd2: val = rec_q.date_view ? rec_q.year : rec_q.hour;
			3'd3, 3'd4, 3'd5: val = rec_q.date_view ? rec_q.month : rec_q.minute;
			default: val = rec_q.date_view ? rec_q.day : rec_q.second;
		endcase
		prod = 15'(val) * 15'(DIV10_MUL);
		tens = prod[14:11];
		units = 4'(val - 7'({3'b000, tens} * 7'd10));
		case (pos_q)
			3'd0, 3'd3, 3'd6: code = {1'b0, tens};
			3'd1, 3'd4, 3'd7: code = {1'b0, units};
			default: code = BLANK_CODE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (advance && at_last) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				pos_q <= pos_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (digit.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= q_head;
		end
		if (advance) begin
			sel_q <= ~(8'd1 << pos_q);
			seg_q <= seg_of(code);
			last_q <= at_last;
			out_rec_q <= rec_q;
		end
	end

	assign digit.valid = out_valid_q;
	assign digit.digit_select = sel_q;
	assign digit.segment_bits = seg_q;
	assign digit.last_digit = last_q;
	assign digit.rtc_write = out_rec_q.rtc_write;
	assign digit.new_hour = out_rec_q.hour;
	assign digit.new_minute = out_rec_q.minute;
	assign digit.new_second = out_rec_q.second;
	assign digit.new_year = out_rec_q.year;
	assign digit.new_month = out_rec_q.month;
	assign digit.new_day = out_rec_q.day;

	`CLSD_ASSERT_IMPL(a_back_one_select, clk, arst_n, out_valid_q, $onehot(~sel_q))
	`CLSD_ASSERT_IMPL(a_back_last_position, clk, arst_n, out_valid_q && last_q, sel_q == 8'h7F)
	`CLSD_ASSERT_IMPL(a_back_pop_at_end, clk, arst_n, pop && busy_q, at_last && advance)
endmodule
